/* sv/slr_pkg.sv */
// shared types, constants and helpers for the stereo loop recorder
// no dependencies; every other file imports this package
`timescale 1ns / 1ps

package slr_pkg;

  localparam int LOOP_DEPTH = 65536;
  localparam int ADDR_W     = $clog2(LOOP_DEPTH);
  localparam int LEN_W      = ADDR_W + 1;
  localparam int SAMPLE_W   = 24;
  localparam int POS_W      = 16;

  // command codes
  localparam logic CMD_FRAME = 1'b0;
  localparam logic CMD_MODE  = 1'b1;

  // mode codes
  localparam logic [1:0] MODE_STANDBY = 2'd0;
  localparam logic [1:0] MODE_RECORD  = 2'd1;
  localparam logic [1:0] MODE_PLAY    = 2'd2;
  localparam logic [1:0] MODE_OVERDUB = 2'd3;

  localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(LOOP_DEPTH);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [ADDR_W-1:0]          addr_t;
  typedef logic [LEN_W-1:0]           len_t;
  typedef logic [POS_W-1:0]           pos_t;

  typedef struct packed {
    sample_t left;
    sample_t right;
  } frame_t;

  // one item on its way from the control stage to the output register
  typedef struct packed {
    logic   play;
    logic   dub;
    logic   full;
    addr_t  addr;
    pos_t   pos;
    frame_t din;
  } slr_op_t;

  function automatic sample_t sat_add(sample_t a, sample_t b);
    logic signed [SAMPLE_W:0] s;
    s = {a[SAMPLE_W-1], a} + {b[SAMPLE_W-1], b};
    if (s[SAMPLE_W] != s[SAMPLE_W-1]) begin
      sat_add = s[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else begin
      sat_add = s[SAMPLE_W-1:0];
    end
  endfunction

  function automatic pos_t to_pos(addr_t a);
    logic [ADDR_W+POS_W-1:0] w;
    w = (ADDR_W + POS_W)'(a);
    to_pos = w[POS_W-1:0];
  endfunction

endpackage

/* sv/slr_in_if.sv */
// input channel of the loop recorder: frame or mode event with valid/ready
// depends on slr_pkg
`timescale 1ns / 1ps

interface slr_in_if;
  import slr_pkg::*;

  logic       valid;
  logic       ready;
  logic       command;
  sample_t    left_in;
  sample_t    right_in;
  logic [1:0] new_mode;

  modport source(output valid, command, left_in, right_in, new_mode, input ready);
  modport sink(input valid, command, left_in, right_in, new_mode, output ready);
endinterface

/* sv/slr_out_if.sv */
// output channel of the loop recorder: one result per item with valid/ready
// depends on slr_pkg
`timescale 1ns / 1ps

interface slr_out_if;
  import slr_pkg::*;

  logic    valid;
  logic    ready;
  sample_t left_out;
  sample_t right_out;
  pos_t    position;
  logic    full_res;

  modport source(output valid, left_out, right_out, position, full_res, input ready);
  modport sink(input valid, left_out, right_out, position, full_res, output ready);
endinterface

/* sv/stereo_loop_recorder.sv */
// top level of the stereo loop recorder: control, loop memory, mixing, output register
// depends on slr_pkg, slr_in_if, slr_out_if, slr_ctrl, slr_mem, slr_mix
`timescale 1ns / 1ps

// Stereo looper with standby, record, play and overdub modes. Each input
// transfer is an audio frame or a mode event and gives exactly one result.
// One item is taken per cycle unless the output stalls, then held in the op
// and output registers. The loop memory is read in the accept cycle; the
// overdub sum is written back as the op enters the output register and
// forwarded to a following read of the same entry, so even a one-frame loop
// runs at full rate. Output backpressure stalls the pipeline and drops ready.
// The memory needs no clearing after reset: only recorded entries are played.

module stereo_loop_recorder (
  input logic      clk,
  input logic      rst,
  slr_in_if.sink   in_ch,
  slr_out_if.source out_ch
);
  import slr_pkg::*;

  logic    adv;
  logic    accept;
  logic    rec_we;
  addr_t   rec_addr;
  addr_t   rd_addr;
  logic    op_valid;
  slr_op_t op;
  frame_t  din;
  frame_t  stored;
  frame_t  dub_data;
  frame_t  play_out;
  logic    dub_we;
  logic    mem_we;
  addr_t   mem_waddr;
  frame_t  mem_wdata;
  logic    out_valid;

  assign adv         = !out_valid || out_ch.ready;
  assign in_ch.ready = adv;
  assign accept      = in_ch.valid && adv;
  assign din.left    = in_ch.left_in;
  assign din.right   = in_ch.right_in;

  slr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .accept   (accept),
    .command  (in_ch.command),
    .new_mode (in_ch.new_mode),
    .din      (din),
    .rec_we   (rec_we),
    .rec_addr (rec_addr),
    .rd_addr  (rd_addr),
    .op_valid (op_valid),
    .op       (op)
  );

  // record and overdub writes never fall on the same cycle
  assign dub_we    = adv && op_valid && op.dub;
  assign mem_we    = dub_we || rec_we;
  assign mem_waddr = dub_we ? op.addr : rec_addr;
  assign mem_wdata = dub_we ? dub_data : din;

  slr_mem u_mem (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .rdata   (stored)
  );

  slr_mix u_mix (
    .op       (op),
    .stored   (stored),
    .dub_data (dub_data),
    .play_out (play_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= op_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && op_valid) begin
      out_ch.left_out  <= play_out.left;
      out_ch.right_out <= play_out.right;
      out_ch.position  <= op.pos;
      out_ch.full_res  <= op.full;
    end
  end

  assign out_ch.valid = out_valid;

endmodule

/* sv/slr_ctrl.sv */
// loop control: mode, loop length and play position, memory request decode
// and the registered operation handed to the mixing stage; depends on slr_pkg
`timescale 1ns / 1ps

module slr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  logic             accept,
  input  logic             command,
  input  logic [1:0]       new_mode,
  input  slr_pkg::frame_t  din,
  output logic             rec_we,
  output slr_pkg::addr_t   rec_addr,
  output slr_pkg::addr_t   rd_addr,
  output logic             op_valid,
  output slr_pkg::slr_op_t op
);
  import slr_pkg::*;

  logic [1:0] mode, mode_next;
  len_t       len, len_next;
  addr_t      pos, pos_next;

  addr_t   p_cur;
  len_t    p_inc;
  addr_t   p_wrap;
  logic    is_frame;
  logic    loop_mode;
  logic    active;
  logic    rec_full;
  slr_op_t op_next;

  always_comb begin
    is_frame  = (command == CMD_FRAME);
    loop_mode = (mode == MODE_PLAY) || (mode == MODE_OVERDUB);
    active    = is_frame && loop_mode && (len != '0);
    rec_full  = is_frame && (mode == MODE_RECORD) && (len == LEN_FULL);

    p_cur  = (LEN_W'(pos) >= len) ? '0 : pos;
    p_inc  = LEN_W'(p_cur) + LEN_W'(1);
    p_wrap = (p_inc >= len) ? '0 : p_inc[ADDR_W-1:0];

    mode_next = mode;
    len_next  = len;
    pos_next  = pos;
    if (!is_frame) begin
      mode_next = new_mode;
      if (new_mode == MODE_RECORD) begin
        len_next = '0;
        pos_next = '0;
      end
    end else begin
      case (mode)
        MODE_RECORD: begin
          if (!rec_full) len_next = len + LEN_W'(1);
        end
        MODE_PLAY, MODE_OVERDUB: begin
          pos_next = active ? p_wrap : '0;
        end
        default: ;
      endcase
    end

    op_next.play = active;
    op_next.dub  = active && (mode == MODE_OVERDUB);
    op_next.full = rec_full;
    op_next.addr = p_cur;
    op_next.pos  = to_pos(pos_next);
    op_next.din  = din;
  end

  assign rec_we   = accept && is_frame && (mode == MODE_RECORD) && !rec_full;
  assign rec_addr = len[ADDR_W-1:0];
  assign rd_addr  = p_cur;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_STANDBY;
      len      <= '0;
      pos      <= '0;
      op_valid <= 1'b0;
    end else begin
      if (accept) begin
        mode <= mode_next;
        len  <= len_next;
        pos  <= pos_next;
      end
      if (adv) op_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) op <= op_next;
  end

endmodule

/* sv/slr_mem.sv */
// loop memory: one write port, one registered read port, and forwarding of
// an overdub write-back that lands on the entry being read; depends on slr_pkg
`timescale 1ns / 1ps

module slr_mem (
  input  logic            clk,
  input  logic            rd_en,
  input  slr_pkg::addr_t  rd_addr,
  input  logic            we,
  input  slr_pkg::addr_t  waddr,
  input  slr_pkg::frame_t wdata,
  output slr_pkg::frame_t rdata
);
  import slr_pkg::*;

  frame_t mem [LOOP_DEPTH];
  frame_t q;
  logic   fwd;
  frame_t fwd_data;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      q        <= mem[rd_addr];
      // the array read above still sees the old entry on a same-edge write
      fwd      <= we && (waddr == rd_addr);
      fwd_data <= wdata;
    end
  end

  assign rdata = fwd ? fwd_data : q;

endmodule

/* sv/slr_mix.sv */
// output selection and saturating overdub sum for one operation
// depends on slr_pkg
`timescale 1ns / 1ps

module slr_mix (
  input  slr_pkg::slr_op_t op,
  input  slr_pkg::frame_t  stored,
  output slr_pkg::frame_t  dub_data,
  output slr_pkg::frame_t  play_out
);
  import slr_pkg::*;

  always_comb begin
    dub_data.left  = sat_add(stored.left, op.din.left);
    dub_data.right = sat_add(stored.right, op.din.right);
    play_out       = op.play ? stored : '0;
  end

endmodule

/* tb/sv/tb_top.sv */
// self-checking bench for stereo_loop_recorder: directed table, then a random mix
// depends on slr_pkg, slr_in_if, slr_out_if and the recorder rtl
`timescale 1ns / 1ps

module tb_top;
  import slr_pkg::*;

  localparam sample_t S_MAX  = 24'sh7FFFFF;
  localparam sample_t S_MIN  = 24'sh800000;
  localparam sample_t S_ZERO = 24'sh000000;
  localparam sample_t S_ONE  = 24'sh000001;
  localparam sample_t S_NEG1 = 24'shFFFFFF;
  localparam int      N_DIR  = 25;
  localparam int      N_RAND = 400;
  localparam int      HOLD_CYCLES = 300;

  typedef struct packed {
    sample_t left;
    sample_t right;
    pos_t    pos;
    logic    full;
  } loop_out_t;

  typedef struct {
    logic       cmd;
    sample_t    l;
    sample_t    r;
    logic [1:0] m;
    bit         typed;
    loop_out_t  res;
  } step_row_t;

  logic clk = 1'b0;
  logic rst;

  slr_in_if  in_ch();
  slr_out_if out_ch();

  stereo_loop_recorder dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // shadow of the looper state
  sample_t    mem_left  [LOOP_DEPTH];
  sample_t    mem_right [LOOP_DEPTH];
  int         rec_len   = 0;
  int         play_pos  = 0;
  logic [1:0] cur_mode  = MODE_STANDBY;

  loop_out_t pending_q[$];
  int fails = 0;
  int n_mode = 0, n_rec = 0, n_drop = 0, n_play = 0, n_dub = 0, n_clamp = 0;
  bit quick = 1'b0;
  int hold_reqs = 0;
  int holds_done = 0;

  function automatic sample_t clamp_add(sample_t a, sample_t b);
    int s;
    s = a + b;
    if (s > 8388607) begin
      n_clamp++;
      return S_MAX;
    end
    if (s < -8388608) begin
      n_clamp++;
      return S_MIN;
    end
    return sample_t'(s);
  endfunction

  function automatic loop_out_t loop_step(logic cmd, sample_t l, sample_t r, logic [1:0] m);
    loop_out_t res;
    int p;
    res = '0;
    if (cmd == CMD_MODE) begin
      cur_mode = m;
      n_mode++;
      if (m == MODE_RECORD) begin
        rec_len  = 0;
        play_pos = 0;
      end
    end else if (cur_mode == MODE_RECORD) begin
      if (rec_len < LOOP_DEPTH) begin
        mem_left[rec_len]  = l;
        mem_right[rec_len] = r;
        rec_len++;
        n_rec++;
      end else begin
        res.full = 1'b1;
        n_drop++;
      end
    end else if (cur_mode == MODE_PLAY || cur_mode == MODE_OVERDUB) begin
      if (rec_len != 0) begin
        p = (play_pos < rec_len) ? play_pos : 0;
        res.left  = mem_left[p];
        res.right = mem_right[p];
        if (cur_mode == MODE_OVERDUB) begin
          mem_left[p]  = clamp_add(res.left, l);
          mem_right[p] = clamp_add(res.right, r);
          n_dub++;
        end else begin
          n_play++;
        end
        p++;
        if (p >= rec_len) p = 0;
        play_pos = p;
      end else begin
        play_pos = 0;
      end
    end
    res.pos = pos_t'(play_pos);
    return res;
  endfunction

  function automatic sample_t any_sample();
    case ($urandom_range(0, 7))
      0: return S_MAX;
      1: return S_MIN;
      2: return S_ZERO;
      3: return S_NEG1;
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic int next_gap();
    int r;
    if (quick) return ($urandom_range(0, 49) == 0) ? $urandom_range(1, 3) : 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // offer one item, wait for the transfer, then queue what it should produce
  task automatic offer_item(logic cmd, sample_t l, sample_t r, logic [1:0] m,
                            bit typed = 1'b0, loop_out_t typed_res = '0);
    loop_out_t pred;
    int gap;
    in_ch.valid    <= 1'b1;
    in_ch.command  <= cmd;
    in_ch.left_in  <= l;
    in_ch.right_in <= r;
    in_ch.new_mode <= m;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    pred = loop_step(cmd, l, r, m);
    pending_q.push_back(typed ? typed_res : pred);
    gap = next_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // directed table; expectations typed in where they are obvious
  step_row_t dir_rows [N_DIR] = '{
    '{CMD_FRAME, S_MAX,  S_MIN,  MODE_STANDBY, 1'b1, '{S_ZERO, S_ZERO, 16'd0, 1'b0}},
    '{CMD_MODE,  S_MAX,  S_MAX,  MODE_PLAY,    1'b1, '{S_ZERO, S_ZERO, 16'd0, 1'b0}},
    '{CMD_FRAME, S_MIN,  S_MAX,  MODE_OVERDUB, 1'b1, '{S_ZERO, S_ZERO, 16'd0, 1'b0}},
    '{CMD_MODE,  S_ZERO, S_ZERO, MODE_OVERDUB, 1'b1, '{S_ZERO, S_ZERO, 16'd0, 1'b0}},
    '{CMD_FRAME, S_MAX,  S_MAX,  MODE_STANDBY, 1'b1, '{S_ZERO, S_ZERO, 16'd0, 1'b0}},
    '{CMD_MODE,  S_NEG1, S_NEG1, MODE_RECORD,  1'b1, '{S_ZERO, S_ZERO, 16'd0, 1'b0}},
    '{CMD_FRAME, S_MAX,  S_MIN,  MODE_STANDBY, 1'b1, '{S_ZERO, S_ZERO, 16'd0, 1'b0}},
    '{CMD_FRAME, S_MIN,  S_MAX,  MODE_OVERDUB, 1'b1, '{S_ZERO, S_ZERO, 16'd0, 1'b0}},
    '{CMD_FRAME, S_ONE,  S_NEG1, MODE_PLAY,    1'b1, '{S_ZERO, S_ZERO, 16'd0, 1'b0}},
    '{CMD_FRAME, S_ZERO, S_ZERO, MODE_RECORD,  1'b1, '{S_ZERO, S_ZERO, 16'd0, 1'b0}},
    '{CMD_MODE,  S_ZERO, S_ZERO, MODE_PLAY,    1'b1, '{S_ZERO, S_ZERO, 16'd0, 1'b0}},
    '{CMD_FRAME, S_ZERO, S_ZERO, MODE_STANDBY, 1'b1, '{S_MAX,  S_MIN,  16'd1, 1'b0}},
    '{CMD_FRAME, S_NEG1, S_ONE,  MODE_OVERDUB, 1'b1, '{S_MIN,  S_MAX,  16'd2, 1'b0}},
    '{CMD_MODE,  S_ZERO, S_ZERO, MODE_OVERDUB, 1'b1, '{S_ZERO, S_ZERO, 16'd2, 1'b0}},
    '{CMD_FRAME, S_ONE,  S_NEG1, MODE_STANDBY, 1'b1, '{S_ONE,  S_NEG1, 16'd3, 1'b0}},
    '{CMD_FRAME, S_MAX,  S_MIN,  MODE_STANDBY, 1'b1, '{S_ZERO, S_ZERO, 16'd0, 1'b0}},
    // the next two clamp at both rails
    '{CMD_FRAME, S_ONE,  S_NEG1, MODE_STANDBY, 1'b1, '{S_MAX,  S_MIN,  16'd1, 1'b0}},
    '{CMD_FRAME, S_NEG1, S_ONE,  MODE_STANDBY, 1'b1, '{S_MIN,  S_MAX,  16'd2, 1'b0}},
    '{CMD_FRAME, S_MIN,  S_MAX,  MODE_STANDBY, 1'b0, '0},
    '{CMD_MODE,  S_ZERO, S_ZERO, MODE_PLAY,    1'b1, '{S_ZERO, S_ZERO, 16'd3, 1'b0}},
    '{CMD_FRAME, S_ZERO, S_ZERO, MODE_STANDBY, 1'b1, '{S_MAX,  S_MIN,  16'd0, 1'b0}},
    '{CMD_FRAME, S_ZERO, S_ZERO, MODE_STANDBY, 1'b0, '0},
    '{CMD_MODE,  S_MAX,  S_MIN,  MODE_STANDBY, 1'b1, '{S_ZERO, S_ZERO, 16'd1, 1'b0}},
    '{CMD_FRAME, S_MAX,  S_MAX,  MODE_OVERDUB, 1'b1, '{S_ZERO, S_ZERO, 16'd1, 1'b0}},
    '{CMD_MODE,  S_MIN,  S_MAX,  MODE_RECORD,  1'b1, '{S_ZERO, S_ZERO, 16'd0, 1'b0}}
  };

  // result side: random stalls plus requested long hold-offs
  initial begin
    int stall;
    stall = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_done < hold_reqs) begin
        holds_done++;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (stall > 0) begin
        out_ch.ready <= 1'b0;
        stall--;
      end else begin
        out_ch.ready <= 1'b1;
        stall = next_gap();
      end
    end
  end

  always @(posedge clk) begin
    loop_out_t want;
    if (rst !== 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_q.size() == 0) begin
        $display("%0t: result with nothing expected: L=%h R=%h pos=%0d full=%b", $time,
                 out_ch.left_out, out_ch.right_out, out_ch.position, out_ch.full_res);
        fails++;
      end else begin
        want = pending_q.pop_front();
        if (out_ch.left_out !== want.left) begin
          $display("%0t: left_out expected %h actual %h", $time, want.left, out_ch.left_out);
          fails++;
        end
        if (out_ch.right_out !== want.right) begin
          $display("%0t: right_out expected %h actual %h", $time, want.right, out_ch.right_out);
          fails++;
        end
        if (out_ch.position !== want.pos) begin
          $display("%0t: position expected %0d actual %0d", $time, want.pos, out_ch.position);
          fails++;
        end
        if (out_ch.full_res !== want.full) begin
          $display("%0t: full_res expected %b actual %b", $time, want.full, out_ch.full_res);
          fails++;
        end
      end
    end
  end

  initial begin
    #50_000_000;
    $display("timeout with %0d results still outstanding", pending_q.size());
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int r;
    logic [1:0] m;
    bit mode_ev;
    rst            <= 1'b1;
    in_ch.valid    <= 1'b0;
    in_ch.command  <= CMD_FRAME;
    in_ch.left_in  <= S_ZERO;
    in_ch.right_in <= S_ZERO;
    in_ch.new_mode <= MODE_STANDBY;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIR; i++) begin
      offer_item(dir_rows[i].cmd, dir_rows[i].l, dir_rows[i].r, dir_rows[i].m,
                 dir_rows[i].typed, dir_rows[i].res);
    end

    // random mix: short loops recorded, then played and overdubbed, with stray events
    for (int i = 0; i < N_RAND; i++) begin
      quick = ((i % 100) >= 85);
      if (i == 120) hold_reqs++;
      r = $urandom_range(0, 99);
      mode_ev = (cur_mode == MODE_RECORD) ? (r < 12 || rec_len >= 24) : (r < 8);
      if (mode_ev) begin
        m = 2'($urandom_range(0, 3));
        if (cur_mode == MODE_RECORD && rec_len >= 24) m = 2'($urandom_range(2, 3));
        offer_item(CMD_MODE, any_sample(), any_sample(), m);
      end else begin
        offer_item(CMD_FRAME, any_sample(), any_sample(), 2'($urandom));
      end
    end

    in_ch.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("run covered %0d mode events, %0d frames recorded, %0d dropped on full memory,",
             n_mode, n_rec, n_drop);
    $display("  %0d frames played, %0d overdubbed with %0d clamped channel sums",
             n_play, n_dub, n_clamp);
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
